### hdl/sdrms_pkg.sv
// Shared types and constants for the stereo downmix and RMS unit.
// Used by the controller, the datapath and the top level; no dependencies.
package sdrms_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int RMS_SHIFT = 10;
  localparam logic [SAMPLE_W-1:0] RMS_MAX = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // take in a request and form the mono sample
    logic square;      // square the mono magnitude
    logic accumulate;  // saturating add; on a closing frame load the root unit
    logic root_step;   // one digit of the square root
    logic emit;        // place the result in the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;        // captured frame closes a block
    logic root_last;   // the current root step is the final one
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

### hdl/sdrms_ctrl.sv
// Controller state machine for the stereo downmix and RMS unit.
// Depends on sdrms_pkg for the command and status structs.
module sdrms_ctrl import sdrms_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SQUARE = 5'b00010,
    ST_ACCUM  = 5'b00100,
    ST_ROOT   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accumulate = 1'b1;
        state_nxt      = sts.last ? ST_ROOT : ST_EMIT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted request always starts the squaring step.
  a_accept_square: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SQUARE))
    else $error("accepted request did not start squaring");

  // The root unit keeps iterating until its final step.
  a_root_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT && !sts.root_last) |=> (state_r == ST_ROOT))
    else $error("root iteration left early");

  // A result placed in the output register frees the input side.
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && sts.out_free) |=> (state_r == ST_IDLE))
    else $error("controller did not return to idle after emitting");

endmodule

### hdl/sdrms_dp.sv
// Datapath for the stereo downmix and RMS unit: mono average, squarer,
// saturating accumulator, digit-serial square root and output register.
// Depends on sdrms_pkg; driven by sdrms_ctrl.
module sdrms_dp import sdrms_pkg::*; #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [SAMPLE_W-1:0] left_sample,
  input  logic [SAMPLE_W-1:0] right_sample,
  input  logic                last_frame,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] mono_unsigned,
  output logic [SAMPLE_W-1:0] rms_level,
  output logic                rms_valid
);

  localparam int RAD_W  = ACC_WIDTH - RMS_SHIFT;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int PAD_W  = 2 * ROOT_W;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [SAMPLE_W-1:0]   mono_r;
  logic                  last_r;
  logic [2*SAMPLE_W-1:0] sq_r;
  logic [ACC_WIDTH-1:0]  acc_r;
  logic [PAD_W-1:0]      rad_r;
  logic [ROOT_W:0]       rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [SAMPLE_W-1:0]   rms_held_r;
  logic                  out_valid_r;
  logic [SAMPLE_W-1:0]   out_mono_r;
  logic [SAMPLE_W-1:0]   out_rms_r;
  logic                  out_flag_r;

  logic [SAMPLE_W:0]     pair_sum;
  logic [SAMPLE_W:0]     pair_adj;
  logic [SAMPLE_W-1:0]   mag;
  logic [ACC_WIDTH:0]    acc_sum;
  logic [ACC_WIDTH-1:0]  acc_sat;
  logic [ROOT_W+2:0]     trial;
  logic [ROOT_W+2:0]     subtrahend;
  logic [ROOT_W+2:0]     diff;
  logic                  take;
  logic [SAMPLE_W-1:0]   rms_new;
  logic                  load_out;

  // Average of the two channels, truncated toward zero.
  assign pair_sum = {left_sample[SAMPLE_W-1], left_sample}
                  + {right_sample[SAMPLE_W-1], right_sample};
  assign pair_adj = pair_sum + (SAMPLE_W+1)'(pair_sum[SAMPLE_W]);

  // Magnitude of the mono sample; the most negative value maps to 32768.
  assign mag = mono_r[SAMPLE_W-1] ? (~mono_r + 1'b1) : mono_r;

  // Saturating accumulation of the square.
  assign acc_sum = {1'b0, acc_r} + (ACC_WIDTH+1)'(sq_r);
  assign acc_sat = acc_sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : acc_sum[ACC_WIDTH-1:0];

  // One restoring digit of the integer square root.
  assign trial      = {rem_r, rad_r[PAD_W-1 -: 2]};
  assign subtrahend = {1'b0, root_r, 2'b01};
  assign diff       = trial - subtrahend;
  assign take       = (trial >= subtrahend);

  // Clip the root to the width of the result field.
  assign rms_new = (root_r > ROOT_W'(RMS_MAX)) ? RMS_MAX : root_r[SAMPLE_W-1:0];

  assign load_out = cmd.emit && (!out_valid_r || out_ready);

  assign sts.last      = last_r;
  assign sts.root_last = (cnt_r == CNT_W'(1));
  assign sts.out_free  = !out_valid_r || out_ready;

  // Capture and squaring registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mono_r <= pair_adj[SAMPLE_W:1];
      last_r <= last_frame;
    end
    if (cmd.square) begin
      sq_r <= mag * mag;
    end
  end

  // Accumulator, cleared when a block closes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.accumulate) begin
      acc_r <= last_r ? '0 : acc_sat;
    end
  end

  // Square root iteration, two radicand bits per step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.accumulate && last_r) begin
      cnt_r <= CNT_W'(ROOT_W);
    end else if (cmd.root_step) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accumulate && last_r) begin
      rad_r  <= PAD_W'(acc_sat[ACC_WIDTH-1:RMS_SHIFT]);
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[PAD_W-3:0], 2'b00};
      rem_r  <= take ? diff[ROOT_W:0] : trial[ROOT_W:0];
      root_r <= {root_r[ROOT_W-2:0], take};
    end
  end

  // Held RMS value, replaced when a closing frame is emitted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rms_held_r <= '0;
    end else if (load_out && last_r) begin
      rms_held_r <= rms_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mono_r <= {~mono_r[SAMPLE_W-1], mono_r[SAMPLE_W-2:0]};
      out_rms_r  <= last_r ? rms_new : rms_held_r;
      out_flag_r <= last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign mono_unsigned = out_mono_r;
  assign rms_level     = out_rms_r;
  assign rms_valid     = out_flag_r;

  // A closing frame leaves the accumulator empty for the next block.
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accumulate && last_r) |=> (acc_r == '0))
    else $error("accumulator not cleared at block end");

  // An emitted result is always presented on the output side.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("emitted result not presented");

  // The root unit only steps while its digit count is non-zero.
  a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.root_step |-> (cnt_r != '0))
    else $error("root step with exhausted digit count");

endmodule

### hdl/stereo_downmix_rms_unit.sv
// Top level of the stereo downmix and RMS unit.
// Depends on sdrms_pkg, sdrms_ctrl and sdrms_dp.
//
//   Channel   Direction  Payload
//   in_       slave      tdata = left_sample, right_sample; tlast = last_frame
//   out_      master     tdata = mono_unsigned, rms_level;  tlast = rms_valid
//
// An ordinary frame passes from acceptance to the next acceptance through
// capture, square, accumulate and emit. A closing frame adds a root step
// for each of its (ACC_WIDTH - 9) / 2 root digits in the digit-serial root
// unit (19 digits at the default width). Synchronous active-low reset
// clears the sum, the held RMS and the output valid flag. A stalled output
// holds the result; a new request is taken meanwhile, and its result waits
// in the emit step until the output register is free.
module stereo_downmix_rms_unit import sdrms_pkg::*; #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2*SAMPLE_W-1:0] in_tdata,   // [15:0] left_sample, [31:16] right_sample
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2*SAMPLE_W-1:0] out_tdata,  // [15:0] mono_unsigned, [31:16] rms_level
  output logic                  out_tlast
);

  cmd_t                cmd;
  sts_t                sts;
  logic [SAMPLE_W-1:0] mono_unsigned;
  logic [SAMPLE_W-1:0] rms_level;

  sdrms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdrms_dp #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .left_sample   (in_tdata[SAMPLE_W-1:0]),
    .right_sample  (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .last_frame    (in_tlast),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .mono_unsigned (mono_unsigned),
    .rms_level     (rms_level),
    .rms_valid     (out_tlast)
  );

  // Pack the result fields, first field in the low half.
  assign out_tdata = {rms_level, mono_unsigned};

endmodule

### tb/tb_stereo_downmix_rms_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for stereo_downmix_rms_unit: a scoreboard class predicts
// each mono sample and block RMS, tasks drive the input and a process the receiver.
// Depends on sdrms_pkg and the RTL of the unit only.
module tb_stereo_downmix_rms_unit;
  import sdrms_pkg::*;

  // A 43-bit sum, narrower than the default, keeps the square root short.
  localparam int ACC_W       = 43;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 1000;
  localparam int DRAIN_WAIT  = 40;
  localparam int LONG_BLOCK  = 200;
  localparam int RANDOM_ITEMS = 1400;
  localparam logic [15:0] FULL_POS = 16'h7FFF;
  localparam logic [15:0] FULL_NEG = 16'h8000;

  // One expected output request.
  typedef struct packed {
    logic [SAMPLE_W-1:0] mono_u;
    logic [SAMPLE_W-1:0] rms;
    logic                closes;
  } mix_result_t;

  // Tracks the running sum and held RMS and keeps the results still to come.
  class downmix_tracker;
    int unsigned acc_bits;
    bit [63:0] square_total;
    bit [SAMPLE_W-1:0] rms_last;
    mix_result_t pending_results[$];
    int frames_in;
    int errors;

    function new(int unsigned bits);
      acc_bits = bits;
      square_total = '0;
      rms_last = '0;
      frames_in = 0;
      errors = 0;
    endfunction

    // Largest r with r*r <= v, built one result bit at a time.
    function bit [63:0] floor_root(bit [63:0] v);
      bit [63:0] r;
      bit [63:0] t;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    // Prints one line for a mismatch and counts it.
    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Predicts the result of an accepted stereo frame.
    function void note_frame(logic [15:0] left, logic [15:0] right, logic closing);
      int lv;
      int rv;
      int mono;
      bit [63:0] sq;
      bit [63:0] top;
      bit [63:0] root;
      mix_result_t res;
      lv = int'($signed(left));
      rv = int'($signed(right));
      mono = (lv + rv) / 2;
      sq = 64'(longint'(mono) * longint'(mono));
      top = (64'd1 << acc_bits) - 64'd1;
      if (square_total > top - sq) square_total = top;
      else square_total += sq;
      res.mono_u = 16'(mono + 32768);
      res.closes = closing;
      // The closing frame's square is already in; take the root and start afresh.
      if (closing) begin
        root = floor_root(square_total >> RMS_SHIFT);
        rms_last = (root > 64'(RMS_MAX)) ? RMS_MAX : root[SAMPLE_W-1:0];
        square_total = '0;
      end
      res.rms = rms_last;
      pending_results.push_back(res);
      frames_in++;
    endfunction

    // Compares an accepted output request with the oldest prediction.
    task check_result(logic [31:0] data, logic closes);
      mix_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result %h/%b with nothing pending", data, closes));
        return;
      end
      want = pending_results.pop_front();
      if (data[15:0] !== want.mono_u)
        report($sformatf("mono_unsigned %h, expected %h", data[15:0], want.mono_u));
      if (data[31:16] !== want.rms)
        report($sformatf("rms_level %0d, expected %0d", data[31:16], want.rms));
      if (closes !== want.closes)
        report($sformatf("rms_valid %b, expected %b", closes, want.closes));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  downmix_tracker tracker = new(ACC_W);
  bit steady = 1'b0;
  int cycles = 0;

  stereo_downmix_rms_unit #(.ACC_WIDTH(ACC_W)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle count and the guard against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata, out_tlast);
  end

  // Receiver: random back-pressure, plus one long hold-off once traffic is under way.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && tracker.frames_in >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // Offers one frame, with random gaps before it, and waits for its acceptance.
  task automatic send_frame(input logic [15:0] left, input logic [15:0] right,
                            input logic closing);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {right, left};
    in_tlast  <= closing;
    do @(posedge clk); while (!in_tready);
    tracker.note_frame(left, right, closing);
  endtask

  // Sends one block of identical frames, the last one closing it.
  task automatic send_block(input logic [15:0] left, input logic [15:0] right, input int len);
    for (int i = 0; i < len; i++) send_frame(left, right, i == len - 1);
  endtask

  // Mostly full-range samples, with some extremes and some values close to zero.
  function automatic logic [15:0] pick_sample();
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 70) return 16'($urandom);
    if (mode < 85) begin
      case ($urandom_range(0, 3))
        0: return FULL_POS;
        1: return FULL_NEG;
        2: return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    return 16'($signed($urandom_range(0, 6)) - 3);
  endfunction

  initial begin
    int sent;
    int len;
    logic [15:0] left;
    logic [15:0] right;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames: rounding towards zero, full-scale sums and RMS before any close.
    send_frame(16'h0000, 16'h0000, 1'b0);
    send_frame(FULL_POS, FULL_POS, 1'b0);
    send_frame(FULL_NEG, FULL_NEG, 1'b0);
    send_frame(FULL_POS, FULL_NEG, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 1'b0);
    send_frame(16'h0001, 16'h0000, 1'b0);
    send_frame(16'hFFFD, 16'h0000, 1'b0);
    send_frame(16'h0003, 16'h0000, 1'b0);
    send_frame(FULL_POS, 16'h7FFE, 1'b0);
    send_frame(FULL_NEG, 16'h8001, 1'b1);
    send_frame(16'h0000, 16'h0000, 1'b1);
    send_frame(FULL_NEG, FULL_NEG, 1'b1);
    send_frame(16'h5555, 16'hAAAA, 1'b0);
    send_frame(16'hAAAA, 16'h5555, 1'b1);
    send_frame(16'h0010, 16'h0020, 1'b0);
    send_frame(16'hFFF0, 16'hFFE0, 1'b1);

    // A long full-scale block that closes with a large RMS.
    send_block(FULL_NEG, FULL_NEG, LONG_BLOCK);

    // Random blocks of random length; a window in the middle runs without gaps.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
      for (int i = 0; i < len; i++) begin
        steady = (sent >= 600 && sent < 900);
        left = pick_sample();
        right = pick_sample();
        send_frame(left, right, i == len - 1);
        sent++;
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    // Drain, then allow for anything the unit still produces.
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
